// ===== src/ttwm_pkg.sv =====
package ttwm_pkg;

   // Tempo table geometry.
   localparam int TABLE_DEPTH = 255;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int BND_W = $clog2(TABLE_DEPTH + 1);

   // Field and datapath widths.
   localparam int CMD_W    = 3;
   localparam int POS_W    = 2;
   localparam int POT_W    = 8;
   localparam int TIDX_W   = 8;
   localparam int WIPER_W  = 8;
   localparam int TEMPO_W  = 11;
   localparam int MS_W     = 16;
   localparam int E_W      = MS_W + 1;
   localparam int K_W      = 6;
   localparam int TMO_W    = 15;
   localparam int PROD_W   = E_W + K_W;
   localparam int NUM_W    = PROD_W + 1;
   localparam int QX_W     = 19;
   localparam int Q_W      = 17;
   localparam int POTM_W   = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Tempo limits and pot thresholds.
   localparam logic [TEMPO_W-1:0] TEMPO_MIN = 11'd36;
   localparam logic [TEMPO_W-1:0] MAX_DIRTY = 11'd1162;
   localparam logic [TEMPO_W-1:0] MAX_CLEAN = 11'd600;
   localparam logic [POT_W-1:0]   POT_MOVE  = 8'd13;

   // Reciprocal constants: x/3 for x below 2**19, y/255 for y below 2**16.
   localparam logic [QX_W-1:0] RECIP3        = 19'd349526;
   localparam int              RECIP3_SHIFT  = 20;
   localparam logic [15:0]     RECIP255      = 16'd32897;
   localparam int              RECIP255_SHIFT = 23;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_BUTTON   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DIVISION = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POT      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd4;

   // Toggle positions.
   localparam logic [POS_W-1:0] POS_LOW    = 2'd0;
   localparam logic [POS_W-1:0] POS_MIDDLE = 2'd1;

   // Register indexes (paddr bit 2).
   localparam logic REG_CLEAN = 1'b0;
   localparam logic REG_DUAL  = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic               pressed;
      logic               half_ms_past;
      logic [POS_W-1:0]   div_position;
      logic               alt_division;
      logic [POT_W-1:0]   pot_value;
      logic [TIDX_W-1:0]  table_index;
      logic [TEMPO_W-1:0] table_value;
   } req_word_type;

   typedef struct packed {
      logic               wiper_valid;
      logic [WIPER_W-1:0] wiper;
      logic [TEMPO_W-1:0] tempo_ms;
      logic [TEMPO_W-1:0] led_tempo_ms;
      logic               tap_mode;
   } rsp_word_type;

   typedef struct packed {
      logic clean;
      logic dual;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_TICK, OP_BUTTON, OP_DIVISION, OP_LOAD,
      OP_MUL, OP_QUOT, OP_UPDATE, OP_HIT_FIRST, OP_RD_LAST, OP_HIT_LAST,
      OP_SEARCH_INIT, OP_RD_MID, OP_HIT_MID, OP_RD_BELOW, OP_RD_ABOVE,
      OP_SET_HI, OP_SET_LO, OP_PICK_BELOW, OP_PICK_ABOVE,
      OP_POT_SCALE, OP_POT_READ, OP_POT_SET, OP_LOAD_OUT
   } op_type;

   typedef struct packed {
      logic   in_ready;
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic             in_take;
      logic [CMD_W-1:0] command;
      logic             tap_go;
      logic             pot_take;
      logic             t_lt_rd;
      logic             t_gt_rd;
      logic             t_eq_rd;
      logic             lo_lt_hi;
      logic             mid_nonzero;
      logic             mid_below_last;
      logic             out_free;
   } dp_status_type;

   // Upper clip limit for the current mode.
   function automatic logic [TEMPO_W-1:0] delay_max(input logic clean);
      return clean ? MAX_CLEAN : MAX_DIRTY;
   endfunction

   // Note division factor k (k/48 of the tap interval).
   function automatic logic [K_W-1:0] division_factor(input logic [POS_W-1:0] pos,
                                                      input logic alt, input logic dual);
      logic [K_W-1:0] k;
      if (pos == POS_LOW) begin
         k = alt ? 6'd16 : 6'd48;
      end else if (pos == POS_MIDDLE) begin
         k = alt ? 6'd8 : 6'd24;
      end else begin
         k = alt ? 6'd12 : 6'd36;
      end
      return dual ? (k >> 1) : k;
   endfunction

   // Tap timeout: delaymax*48/k + 800 for every reachable factor.
   function automatic logic [TMO_W-1:0] timeout_for(input logic [K_W-1:0] k,
                                                    input logic clean);
      logic [TMO_W-1:0] t;
      case (k)
         6'd48:   t = clean ? 15'd1400 : 15'd1962;
         6'd24:   t = clean ? 15'd2000 : 15'd3124;
         6'd36:   t = clean ? 15'd1600 : 15'd2349;
         6'd16:   t = clean ? 15'd2600 : 15'd4286;
         6'd8:    t = clean ? 15'd4400 : 15'd7772;
         6'd12:   t = clean ? 15'd3200 : 15'd5448;
         6'd18:   t = clean ? 15'd2400 : 15'd3898;
         6'd4:    t = clean ? 15'd8000 : 15'd14744;
         6'd6:    t = clean ? 15'd5600 : 15'd10096;
         default: t = clean ? 15'd1400 : 15'd1962;
      endcase
      return t;
   endfunction

   // Clip a tempo into 36..delaymax.
   function automatic logic [TEMPO_W-1:0] clip_tempo(input logic [E_W-1:0] v,
                                                     input logic clean);
      logic [TEMPO_W-1:0] top;
      top = delay_max(clean);
      if (v < E_W'(TEMPO_MIN)) begin
         return TEMPO_MIN;
      end else if (v > E_W'(top)) begin
         return top;
      end
      return TEMPO_W'(v);
   endfunction

endpackage

// ===== src/ttwm_req_if.sv =====
interface ttwm_req_if;
   import ttwm_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ===== src/ttwm_rsp_if.sv =====
interface ttwm_rsp_if;
   import ttwm_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ===== src/ttwm_datapath.sv =====
module ttwm_datapath (
   input  logic                    clock,
   input  logic                    reset,
   ttwm_req_if.sink                req_ch,
   ttwm_rsp_if.source              rsp_ch,
   input  ttwm_pkg::cfg_type       cfg,
   input  ttwm_pkg::ctrl_cmd_type  cmd,
   output ttwm_pkg::dp_status_type status
);
   import ttwm_pkg::*;

   localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

   // Tempo table, loaded word by word, one registered read port.
   logic [TEMPO_W-1:0] table_mem [TABLE_DEPTH];
   logic [TEMPO_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;

   req_word_type       item_ff;
   logic [MS_W-1:0]    ms_ff, ms_in;
   logic [1:0]         tap_count_ff, tap_count_in;
   logic               last_pressed_ff, last_pressed_in;
   logic               tap_active_ff, tap_active_in;
   logic [TEMPO_W-1:0] tempo_ff, tempo_in;
   logic [TEMPO_W-1:0] led_ff, led_in;
   logic [K_W-1:0]     div_ff, div_in;
   logic [POT_W-1:0]   prev_pot_ff, prev_pot_in;
   logic [E_W-1:0]     e_ff, e_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [Q_W-1:0]     quot_ff, quot_in;
   logic [IDX_W-1:0]   pot_idx_ff, pot_idx_in;
   logic [BND_W-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0]   mid_ff, mid_in;
   logic [TEMPO_W-1:0] vmid_ff, vmid_in;
   logic [IDX_W-1:0]   wiper_ff, wiper_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               in_take;
   logic [TMO_W-1:0]   timeout_cur, timeout_new;
   logic [MS_W-1:0]    ms_inc;
   logic [K_W-1:0]     k_new;
   logic [POT_W-1:0]   pot_diff;
   logic [E_W-1:0]     e_cur;
   logic [NUM_W-1:0]   avg_num;
   logic [QX_W-1:0]    quot_x;
   logic [2*QX_W-1:0]  quot_prod;
   logic [E_W-1:0]     led_avg;
   logic [E_W:0]       led_sum;
   logic [POTM_W-1:0]  pot_mul;
   logic [31:0]        pot_prod;
   logic [POT_W-1:0]   pot_scaled;
   logic [BND_W:0]     mid_sum;
   logic [IDX_W-1:0]   mid_new;
   logic [TEMPO_W:0]   gap_low, gap_high;

   assign in_take      = req_ch.valid & cmd.in_ready;
   assign req_ch.ready = cmd.in_ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_word_ff;

   // Shared arithmetic.
   always_comb begin
      timeout_cur = timeout_for(div_ff, cfg.clean);
      k_new       = division_factor(item_ff.div_position, item_ff.alt_division, cfg.dual);
      timeout_new = timeout_for(k_new, cfg.clean);
      ms_inc      = (ms_ff != '1) ? ms_ff + MS_W'(1) : ms_ff;
      pot_diff    = (item_ff.pot_value >= prev_pot_ff) ? item_ff.pot_value - prev_pot_ff
                                                       : prev_pot_ff - item_ff.pot_value;
      e_cur       = E_W'(ms_ff) + E_W'(item_ff.half_ms_past);
      // Average numerator 48*tempo + e*k + 48, later divided by 96.
      avg_num     = NUM_W'({tempo_ff, 5'b0}) + NUM_W'({tempo_ff, 4'b0})
                    + NUM_W'(prod_ff) + NUM_W'(48);
      quot_x      = (tap_count_ff == 2'd1) ? QX_W'(prod_ff >> 4) : QX_W'(avg_num >> 5);
      quot_prod   = (2*QX_W)'(quot_x) * (2*QX_W)'(RECIP3);
      led_sum     = (E_W+1)'(led_ff) + (E_W+1)'(e_ff) + (E_W+1)'(1);
      led_avg     = E_W'(led_sum >> 1);
      // Clean mode scales the pot by 127/255.
      pot_mul     = {item_ff.pot_value, 7'b0} - POTM_W'(item_ff.pot_value);
      pot_prod    = 32'(pot_mul) * 32'(RECIP255);
      pot_scaled  = cfg.clean ? POT_W'(pot_prod >> RECIP255_SHIFT) : item_ff.pot_value;
      mid_sum     = (BND_W+1)'(lo_ff) + (BND_W+1)'(hi_ff);
      mid_new     = IDX_W'(mid_sum >> 1);
      gap_low     = (TEMPO_W+1)'(tempo_ff) - (TEMPO_W+1)'(vmid_ff);
      gap_high    = (TEMPO_W+1)'(rd_data_ff) - (TEMPO_W+1)'(tempo_ff);
   end

   // Table read address for the current step.
   always_comb begin
      case (cmd.op)
         OP_UPDATE:   rd_addr = '0;
         OP_RD_LAST:  rd_addr = LAST;
         OP_RD_MID:   rd_addr = mid_new;
         OP_RD_BELOW: rd_addr = mid_ff - IDX_W'(1);
         OP_RD_ABOVE: rd_addr = mid_ff + IDX_W'(1);
         OP_POT_READ: rd_addr = pot_idx_ff;
         default:     rd_addr = mid_ff;
      endcase
   end

   // Next state for every operation.
   always_comb begin
      ms_in           = ms_ff;
      tap_count_in    = tap_count_ff;
      last_pressed_in = last_pressed_ff;
      tap_active_in   = tap_active_ff;
      tempo_in        = tempo_ff;
      led_in          = led_ff;
      div_in          = div_ff;
      prev_pot_in     = prev_pot_ff;
      e_in            = e_ff;
      prod_in         = prod_ff;
      quot_in         = quot_ff;
      pot_idx_in      = pot_idx_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      vmid_in         = vmid_ff;
      wiper_in        = wiper_ff;
      hit_in          = in_take ? 1'b0 : hit_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ch.ready;
      rsp_word_in     = rsp_word_ff;
      case (cmd.op)
         OP_TICK: begin
            ms_in = ms_inc;
            if (ms_inc > MS_W'(timeout_cur)) begin
               ms_in        = '0;
               tap_count_in = '0;
            end
         end
         OP_BUTTON: begin
            if (!item_ff.pressed) begin
               last_pressed_in = 1'b0;
            end else if (!last_pressed_ff) begin
               if (tap_count_ff == 2'd0) begin
                  ms_in        = '0;
                  tap_count_in = 2'd1;
               end
               last_pressed_in = 1'b1;
            end
         end
         OP_DIVISION: begin
            div_in = k_new;
            if (item_ff.alt_division) begin
               tap_count_in    = '0;
               last_pressed_in = 1'b1;
            end
            if (ms_ff > MS_W'(timeout_new)) begin
               ms_in        = '0;
               tap_count_in = '0;
            end
         end
         OP_MUL: begin
            e_in    = e_cur;
            prod_in = PROD_W'(e_cur) * PROD_W'(div_ff);
         end
         OP_QUOT: begin
            quot_in = Q_W'(quot_prod >> RECIP3_SHIFT);
         end
         OP_UPDATE: begin
            tempo_in        = clip_tempo(quot_ff, cfg.clean);
            led_in          = clip_tempo((tap_count_ff == 2'd1) ? e_ff : led_avg, cfg.clean);
            tap_count_in    = (tap_count_ff < 2'd2) ? tap_count_ff + 2'd1 : tap_count_ff;
            ms_in           = '0;
            tap_active_in   = 1'b1;
            last_pressed_in = 1'b1;
         end
         OP_HIT_FIRST: begin
            wiper_in = '0;
            hit_in   = 1'b1;
         end
         OP_HIT_LAST: begin
            wiper_in = LAST;
            hit_in   = 1'b1;
         end
         OP_SEARCH_INIT: begin
            lo_in  = '0;
            hi_in  = BND_W'(TABLE_DEPTH);
            mid_in = '0;
         end
         OP_RD_MID: mid_in = mid_new;
         OP_HIT_MID: begin
            wiper_in = mid_ff;
            hit_in   = 1'b1;
         end
         OP_RD_BELOW: vmid_in = rd_data_ff;
         OP_RD_ABOVE: vmid_in = rd_data_ff;
         OP_SET_HI:   hi_in = BND_W'(mid_ff);
         OP_SET_LO:   lo_in = BND_W'(mid_ff) + BND_W'(1);
         OP_PICK_BELOW: begin
            // Lower neighbor is in rd_data, upper in vmid; ties go up.
            wiper_in = ((TEMPO_W+1)'(tempo_ff) - (TEMPO_W+1)'(rd_data_ff) >=
                        (TEMPO_W+1)'(vmid_ff) - (TEMPO_W+1)'(tempo_ff))
                       ? mid_ff : mid_ff - IDX_W'(1);
            hit_in   = 1'b1;
         end
         OP_PICK_ABOVE: begin
            wiper_in = (gap_low >= gap_high) ? mid_ff + IDX_W'(1) : mid_ff;
            hit_in   = 1'b1;
         end
         OP_POT_SCALE: begin
            pot_idx_in = (int'(pot_scaled) > TABLE_DEPTH - 1) ? LAST : IDX_W'(pot_scaled);
         end
         OP_POT_SET: begin
            tempo_in      = rd_data_ff;
            wiper_in      = pot_idx_ff;
            hit_in        = 1'b1;
            prev_pot_in   = item_ff.pot_value;
            tap_active_in = 1'b0;
         end
         OP_LOAD_OUT: begin
            rsp_valid_in             = 1'b1;
            rsp_word_in.wiper_valid  = hit_ff;
            rsp_word_in.wiper        = hit_ff ? WIPER_W'(wiper_ff) : '0;
            rsp_word_in.tempo_ms     = tempo_ff;
            rsp_word_in.led_tempo_ms = led_ff;
            rsp_word_in.tap_mode     = tap_active_ff;
         end
         default: begin
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff           <= '0;
         tap_count_ff    <= '0;
         last_pressed_ff <= 1'b0;
         tap_active_ff   <= 1'b0;
         tempo_ff        <= '0;
         led_ff          <= '0;
         div_ff          <= 6'd48;
         prev_pot_ff     <= '0;
         lo_ff           <= '0;
         hi_ff           <= '0;
         hit_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         ms_ff           <= ms_in;
         tap_count_ff    <= tap_count_in;
         last_pressed_ff <= last_pressed_in;
         tap_active_ff   <= tap_active_in;
         tempo_ff        <= tempo_in;
         led_ff          <= led_in;
         div_ff          <= div_in;
         prev_pot_ff     <= prev_pot_in;
         lo_ff           <= lo_in;
         hi_ff           <= hi_in;
         hit_ff          <= hit_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (in_take) begin
         item_ff <= req_ch.payload;
      end
      e_ff        <= e_in;
      prod_ff     <= prod_in;
      quot_ff     <= quot_in;
      pot_idx_ff  <= pot_idx_in;
      mid_ff      <= mid_in;
      vmid_ff     <= vmid_in;
      wiper_ff    <= wiper_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Table memory.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && int'(item_ff.table_index) < TABLE_DEPTH) begin
         table_mem[IDX_W'(item_ff.table_index)] <= item_ff.table_value;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // Status toward the controller.
   always_comb begin
      status.in_take        = in_take;
      status.command        = item_ff.command;
      status.tap_go         = item_ff.pressed & ~last_pressed_ff & (tap_count_ff != 2'd0);
      status.pot_take       = ~tap_active_ff | (pot_diff >= POT_MOVE);
      status.t_lt_rd        = tempo_ff < rd_data_ff;
      status.t_gt_rd        = tempo_ff > rd_data_ff;
      status.t_eq_rd        = tempo_ff == rd_data_ff;
      status.lo_lt_hi       = lo_ff < hi_ff;
      status.mid_nonzero    = mid_ff != '0;
      status.mid_below_last = mid_ff < LAST;
      status.out_free       = ~rsp_valid_ff | rsp_ch.ready;
   end

`ifndef SYNTHESIS
   a_tap_count_sat: assert property (@(posedge clock) disable iff (reset)
      tap_count_ff != 2'd3)
      else $error("tap count passed saturation");
   a_tap_tempo_clipped: assert property (@(posedge clock) disable iff (reset)
      tap_active_ff |-> (tempo_ff >= TEMPO_MIN && led_ff >= TEMPO_MIN))
      else $error("tap tempo below minimum");
   a_wiper_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.wiper_valid) |-> (rsp_word_ff.wiper == '0))
      else $error("wiper not zero without wiper_valid");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      lo_ff <= hi_ff)
      else $error("search bounds crossed");
`endif

endmodule

// ===== src/ttwm_controller.sv =====
module ttwm_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  ttwm_pkg::dp_status_type status,
   output ttwm_pkg::ctrl_cmd_type  cmd
);
   import ttwm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_MUL, S_QUOT, S_UPDATE, S_CHK_FIRST, S_CHK_LAST,
      S_LOOP, S_MID, S_BELOW, S_ABOVE, S_POT_SCALE, S_POT_READ, S_POT_SET, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Sequencing and operation decode.
   always_comb begin
      state_in     = state_ff;
      cmd.in_ready = 1'b0;
      cmd.op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (status.in_take) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            case (status.command)
               CMD_TICK:     cmd.op = OP_TICK;
               CMD_BUTTON: begin
                  if (status.tap_go) begin
                     state_in = S_MUL;
                  end else begin
                     cmd.op = OP_BUTTON;
                  end
               end
               CMD_DIVISION: cmd.op = OP_DIVISION;
               CMD_POT: begin
                  if (status.pot_take) begin
                     state_in = S_POT_SCALE;
                  end
               end
               CMD_LOAD:     cmd.op = OP_LOAD;
               default:      cmd.op = OP_NONE;
            endcase
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_QUOT;
         end
         S_QUOT: begin
            cmd.op   = OP_QUOT;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.op   = OP_UPDATE;
            state_in = S_CHK_FIRST;
         end
         // Targets at or below the first entry map to index zero.
         S_CHK_FIRST: begin
            if (!status.t_gt_rd) begin
               cmd.op   = OP_HIT_FIRST;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_RD_LAST;
               state_in = S_CHK_LAST;
            end
         end
         S_CHK_LAST: begin
            if (!status.t_lt_rd) begin
               cmd.op   = OP_HIT_LAST;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_SEARCH_INIT;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (status.lo_lt_hi) begin
               cmd.op   = OP_RD_MID;
               state_in = S_MID;
            end else begin
               cmd.op   = OP_HIT_MID;
               state_in = S_DONE;
            end
         end
         // Compare with the midpoint, then look at the neighbor on that side.
         S_MID: begin
            if (status.t_eq_rd) begin
               cmd.op   = OP_HIT_MID;
               state_in = S_DONE;
            end else if (status.t_lt_rd) begin
               if (status.mid_nonzero) begin
                  cmd.op   = OP_RD_BELOW;
                  state_in = S_BELOW;
               end else begin
                  cmd.op   = OP_SET_HI;
                  state_in = S_LOOP;
               end
            end else begin
               if (status.mid_below_last) begin
                  cmd.op   = OP_RD_ABOVE;
                  state_in = S_ABOVE;
               end else begin
                  cmd.op   = OP_SET_LO;
                  state_in = S_LOOP;
               end
            end
         end
         S_BELOW: begin
            if (status.t_gt_rd) begin
               cmd.op   = OP_PICK_BELOW;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_SET_HI;
               state_in = S_LOOP;
            end
         end
         S_ABOVE: begin
            if (status.t_lt_rd) begin
               cmd.op   = OP_PICK_ABOVE;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_SET_LO;
               state_in = S_LOOP;
            end
         end
         S_POT_SCALE: begin
            cmd.op   = OP_POT_SCALE;
            state_in = S_POT_READ;
         end
         S_POT_READ: begin
            cmd.op   = OP_POT_READ;
            state_in = S_POT_SET;
         end
         S_POT_SET: begin
            cmd.op   = OP_POT_SET;
            state_in = S_DONE;
         end
         // Hand the word to the output register once it is free.
         S_DONE: begin
            if (status.out_free) begin
               cmd.op   = OP_LOAD_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/tap_tempo_wiper_mapper_top.sv =====
// Tap tempo detector and wiper mapper. Each request word (ms tick, button sample,
// division change, pot sample or table load) yields exactly one response word on
// the rsp channel, which is held in an output register so the next request can be
// accepted while the response waits. A tick, button, division, load or unused word,
// and a pot word that leaves the wiper alone, is handled in the dispatch step before
// the response register is loaded; a pot word that moves the wiper steps through
// scale, table read and set. A completed tap steps through multiply, quotient and
// update, then checks the first table entry and, above it, the last one; between
// the two it runs a binary search over the single-port tempo table of 255 entries,
// one registered read per cycle, halving the range at each step. A word waits for
// its response to be loaded for as long as the response register stays full.
// Table entries must be loaded before the search or pot can read them.
// clean_mode is at byte address 0 and dual_mode at byte address 4 on the csr port.
module tap_tempo_wiper_mapper_top (
   input  logic                                clock,
   input  logic                                reset,
   ttwm_req_if.sink                            req_ch,
   ttwm_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ttwm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ttwm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ttwm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import ttwm_pkg::*;

   logic          clean_ff, clean_in;
   logic          dual_ff, dual_in;
   logic          csr_write;
   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      clean_in = clean_ff;
      dual_in  = dual_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_CLEAN) begin
            clean_in = csr_pwdata[0];
         end else begin
            dual_in = csr_pwdata[0];
         end
      end
      csr_prdata = (csr_paddr[2] == REG_CLEAN) ? CSR_DATA_W'(clean_ff) : CSR_DATA_W'(dual_ff);
      cfg.clean  = clean_ff;
      cfg.dual   = dual_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clean_ff <= 1'b0;
         dual_ff  <= 1'b0;
      end else begin
         clean_ff <= clean_in;
         dual_ff  <= dual_in;
      end
   end

   ttwm_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   ttwm_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cfg    (cfg),
      .cmd    (cmd),
      .status (status)
   );

endmodule
